// File: sv/clis_pkg.sv
// shared constants and types for the centered integer line scaler
`default_nettype none

package clis_pkg;

   localparam int unsigned DEF_PANEL_WIDTH  = 1024;
   localparam int unsigned DEF_PANEL_HEIGHT = 600;

   localparam int unsigned FRAME_DIM_W = 10;
   localparam int unsigned SCALE_W     = 2;
   localparam int unsigned AREA_W      = 2 * FRAME_DIM_W;
   localparam int unsigned SRC_ADDR_W  = 18;

   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_SCALE        = 2'd2
   } reg_index_type;

   localparam logic [FRAME_DIM_W-1:0] RST_FRAME_WIDTH  = 10'd256;
   localparam logic [FRAME_DIM_W-1:0] RST_FRAME_HEIGHT = 10'd224;
   localparam logic [SCALE_W-1:0]     RST_SCALE        = 2'd1;

   localparam logic [SCALE_W-1:0] SCALE_ONE   = 2'd1;
   localparam logic [SCALE_W-1:0] SCALE_TWO   = 2'd2;
   localparam logic [SCALE_W-1:0] SCALE_THREE = 2'd3;

endpackage

`default_nettype wire

// File: sv/clis_if.sv
// valid/ready channel interfaces for line events and scan-out results
`default_nettype none

interface clis_req_if import clis_pkg::*; ();
   logic valid;
   logic ready;
   logic mode;
   logic restart;

   modport source (output valid, output mode, output restart, input ready);
   modport sink (input valid, input mode, input restart, output ready);
endinterface

interface clis_rsp_if import clis_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  show_source;
   logic [SRC_ADDR_W-1:0] src_addr;
   logic                  line_end;
   logic                  frame_done;

   modport source (
      output valid, output show_source, output src_addr, output line_end,
      output frame_done, input ready
   );
   modport sink (
      input valid, input show_source, input src_addr, input line_end,
      input frame_done, output ready
   );
endinterface

`default_nettype wire

// File: sv/centered_integer_line_scaler.sv
// centered integer line scaler: scan-out address generator with letterboxing
//
// req_chan carries one transaction per panel event: mode 0 is a pixel tick,
// mode 1 a line start (restart with it rescans from the second line).
// rsp_chan returns one transaction per request: show_source/src_addr give
// the framebuffer pixel to show or black, line_end marks the last tick of a
// panel line and frame_done the line start that closes a frame.
// csr_* is an APB-style port with frame_width at 0x0, frame_height at 0x4
// and scale at 0x8; pready is always high.
// The response is valid in the cycle after a request is accepted and
// throughput is one transaction per cycle while req ready is high; the
// single response register sets both. Margins, offsets and run width come
// from a 3-stage pipeline on the registers; after reset and any mapped
// register write req ready is low while it settles and the line pointer reloads.
// Reset is synchronous: registers return to 256x224 at scale 1, line and
// pixel counters clear and the response register empties.
// When the receiver stalls, the response holds and req ready drops until it
// is taken.
`default_nettype none

module centered_integer_line_scaler import clis_pkg::*; #(
   parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
   parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   clis_req_if.sink                   req_chan,
   clis_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int unsigned PX_W   = $clog2(PANEL_WIDTH);
   localparam int unsigned LD_W   = $clog2(PANEL_HEIGHT + 1);
   localparam int unsigned DV_W   = $clog2(PANEL_WIDTH + PANEL_HEIGHT
                                           + (3 << FRAME_DIM_W)) + 1;
   localparam int unsigned OFS_W  = $clog2(2 * PANEL_HEIGHT + (2 << FRAME_DIM_W))
                                    + FRAME_DIM_W + 1;
   localparam int unsigned SETTLE = 4;
   localparam int unsigned CNT_W  = $clog2(SETTLE + 1);

   localparam int unsigned H_LIM1 = PANEL_HEIGHT;
   localparam int unsigned H_LIM2 = PANEL_HEIGHT / 2;
   localparam int unsigned H_LIM3 = PANEL_HEIGHT / 3;
   localparam int unsigned W_LIM1 = PANEL_WIDTH;
   localparam int unsigned W_LIM2 = PANEL_WIDTH / 2;
   localparam int unsigned W_LIM3 = PANEL_WIDTH / 3;

   localparam int unsigned RECIP3   = 21846;
   localparam int unsigned RECIP_SH = 16;

   function automatic logic signed [DV_W-1:0] half_trunc(
      input logic signed [DV_W-1:0] x
   );
      logic [DV_W-1:0] m;
      logic [DV_W-1:0] q;
      m = x[DV_W-1] ? $unsigned(-x) : $unsigned(x);
      q = m >> 1;
      return x[DV_W-1] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [DV_W-1:0] div_scale(
      input logic signed [DV_W-1:0] x,
      input logic [SCALE_W-1:0]     s
   );
      logic [DV_W-1:0] m;
      logic [DV_W-1:0] q;
      m = x[DV_W-1] ? $unsigned(-x) : $unsigned(x);
      unique case (s)
         SCALE_TWO:   q = m >> 1;
         SCALE_THREE: q = DV_W'((32'(m) * RECIP3) >> RECIP_SH);
         default:     q = m;
      endcase
      return x[DV_W-1] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [LD_W-1:0] height_limit(input logic [SCALE_W-1:0] s);
      logic [LD_W-1:0] lim;
      unique case (s)
         SCALE_TWO:   lim = LD_W'(H_LIM2);
         SCALE_THREE: lim = LD_W'(H_LIM3);
         default:     lim = LD_W'(H_LIM1);
      endcase
      return lim;
   endfunction

   function automatic logic [FRAME_DIM_W-1:0] width_limit(input logic [SCALE_W-1:0] s);
      logic [FRAME_DIM_W-1:0] lim;
      unique case (s)
         SCALE_TWO:   lim = FRAME_DIM_W'(W_LIM2);
         SCALE_THREE: lim = FRAME_DIM_W'(W_LIM3);
         default:     lim = FRAME_DIM_W'(W_LIM1);
      endcase
      return lim;
   endfunction

   // configuration registers
   logic [FRAME_DIM_W-1:0] frame_width_ff;
   logic [FRAME_DIM_W-1:0] frame_height_ff;
   logic [SCALE_W-1:0]     scale_ff;
   logic [SCALE_W-1:0]     s_eff;
   logic                   csr_write;
   logic                   csr_hit;
   reg_index_type          csr_index;

   // derivation pipeline
   logic [FRAME_DIM_W+1:0]          ws;
   logic [FRAME_DIM_W+1:0]          hs;
   logic signed [DV_W-1:0]          mx_raw;
   logic signed [DV_W-1:0]          my_raw;
   logic signed [DV_W-1:0]          mx_ff;
   logic signed [DV_W-1:0]          my_ff;
   logic [AREA_W-1:0]               area_ff;
   logic signed [DV_W-1:0]          qmx_ff;
   logic signed [DV_W-1:0]          qmy_ff;
   logic signed [DV_W+FRAME_DIM_W:0] prod_my;
   logic signed [OFS_W-1:0]         start_offset_ff;
   logic [PX_W-1:0]                 left_margin_ff;
   logic [FRAME_DIM_W-1:0]          run_width_ff;
   logic [CNT_W-1:0]                settle_cnt_ff;
   logic                            settle_load;

   // scan state
   logic signed [OFS_W-1:0] next_line_src_ff, next_line_src_in;
   logic [SRC_ADDR_W-1:0]   line_base_ff, line_base_in;
   logic                    line_visible_ff, line_visible_in;
   logic [LD_W-1:0]         lines_done_ff, lines_done_in;
   logic [PX_W-1:0]         pixel_x_ff, pixel_x_in;
   logic [1:0]              repeat_count_ff, repeat_count_in;
   logic [FRAME_DIM_W-1:0]  column_ff, column_in;

   logic signed [OFS_W-1:0] width_ext;
   logic signed [OFS_W-1:0] area_ext;
   logic signed [OFS_W-1:0] nls_sel;
   logic [LD_W-1:0]         ld_sel;
   logic [LD_W-1:0]         ld_inc;
   logic                    pix_vis;
   logic                    pix_last;
   logic [1:0]              rep_inc;

   // response register
   logic                  req_fire;
   logic                  rsp_valid_ff;
   logic                  show_ff, show_in;
   logic [SRC_ADDR_W-1:0] addr_ff, addr_in;
   logic                  lend_ff, lend_in;
   logic                  fdone_ff, fdone_in;

   assign s_eff     = (scale_ff == '0) ? SCALE_ONE : scale_ff;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         REG_FRAME_WIDTH: begin
            csr_hit    = 1'b1;
            csr_prdata = CSR_DATA_W'(frame_width_ff);
         end
         REG_FRAME_HEIGHT: begin
            csr_hit    = 1'b1;
            csr_prdata = CSR_DATA_W'(frame_height_ff);
         end
         REG_SCALE: begin
            csr_hit    = 1'b1;
            csr_prdata = CSR_DATA_W'(scale_ff);
         end
         default: begin
            csr_hit    = 1'b0;
            csr_prdata = '0;
         end
      endcase
   end

   // margins from panel minus scaled frame, halved toward zero
   always_comb begin
      ws      = (FRAME_DIM_W + 2)'(frame_width_ff) * (FRAME_DIM_W + 2)'(s_eff);
      hs      = (FRAME_DIM_W + 2)'(frame_height_ff) * (FRAME_DIM_W + 2)'(s_eff);
      mx_raw  = $signed(DV_W'(PANEL_WIDTH)) - $signed(DV_W'(ws));
      my_raw  = $signed(DV_W'(PANEL_HEIGHT)) - $signed(DV_W'(hs));
      prod_my = qmy_ff * $signed({1'b0, frame_width_ff});
   end

   always_ff @(posedge clock) begin
      mx_ff   <= half_trunc(mx_raw);
      my_ff   <= half_trunc(my_raw);
      area_ff <= AREA_W'(frame_width_ff) * AREA_W'(frame_height_ff);
      qmx_ff  <= div_scale(mx_ff, s_eff);
      qmy_ff  <= div_scale(-my_ff, s_eff);
      start_offset_ff <= OFS_W'(prod_my) - (mx_ff[DV_W-1] ? OFS_W'(qmx_ff) : '0);
      left_margin_ff  <= mx_ff[DV_W-1] ? '0 : mx_ff[PX_W-1:0];
      run_width_ff    <= mx_ff[DV_W-1] ? width_limit(s_eff) : frame_width_ff;
   end

   assign settle_load = (settle_cnt_ff == CNT_W'(1));
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (settle_cnt_ff == '0) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      width_ext = $signed(OFS_W'({1'b0, frame_width_ff}));
      area_ext  = $signed(OFS_W'({1'b0, area_ff}));
      nls_sel   = req_chan.restart ? start_offset_ff + width_ext : next_line_src_ff;
      ld_sel    = req_chan.restart ? LD_W'(1) : lines_done_ff;
      ld_inc    = LD_W'(ld_sel + 1'b1);
      pix_vis   = line_visible_ff && (pixel_x_ff >= left_margin_ff)
                  && (column_ff < run_width_ff);
      pix_last  = (pixel_x_ff >= PX_W'(PANEL_WIDTH - 1));
      rep_inc   = 2'(repeat_count_ff + 1'b1);

      next_line_src_in = next_line_src_ff;
      line_base_in     = line_base_ff;
      line_visible_in  = line_visible_ff;
      lines_done_in    = lines_done_ff;
      pixel_x_in       = pixel_x_ff;
      repeat_count_in  = repeat_count_ff;
      column_in        = column_ff;
      show_in          = 1'b0;
      addr_in          = '0;
      lend_in          = 1'b0;
      fdone_in         = 1'b0;

      if (req_chan.mode) begin
         line_visible_in = !nls_sel[OFS_W-1] && (nls_sel < area_ext);
         line_base_in    = nls_sel[SRC_ADDR_W-1:0];
         pixel_x_in      = '0;
         repeat_count_in = '0;
         column_in       = '0;
         if (ld_inc >= height_limit(s_eff)) begin
            lines_done_in    = '0;
            next_line_src_in = start_offset_ff;
            fdone_in         = 1'b1;
         end else begin
            lines_done_in    = ld_inc;
            next_line_src_in = nls_sel + width_ext;
         end
      end else begin
         if (pix_vis) begin
            show_in = 1'b1;
            addr_in = SRC_ADDR_W'(line_base_ff + SRC_ADDR_W'(column_ff));
            if (rep_inc >= s_eff) begin
               repeat_count_in = '0;
               column_in       = FRAME_DIM_W'(column_ff + 1'b1);
            end else begin
               repeat_count_in = rep_inc;
            end
         end
         if (pix_last) begin
            lend_in         = 1'b1;
            pixel_x_in      = '0;
            repeat_count_in = '0;
            column_in       = '0;
         end else begin
            pixel_x_in = PX_W'(pixel_x_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         scale_ff        <= RST_SCALE;
         settle_cnt_ff   <= CNT_W'(SETTLE);
         rsp_valid_ff    <= 1'b0;
         line_visible_ff <= 1'b0;
         lines_done_ff   <= '0;
         pixel_x_ff      <= '0;
         repeat_count_ff <= '0;
         column_ff       <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[FRAME_DIM_W-1:0];
               REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[FRAME_DIM_W-1:0];
               REG_SCALE:        scale_ff        <= csr_pwdata[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (csr_write && csr_hit) begin
            settle_cnt_ff <= CNT_W'(SETTLE);
         end else if (settle_cnt_ff != '0) begin
            settle_cnt_ff <= CNT_W'(settle_cnt_ff - 1'b1);
         end
         if (req_fire) begin
            rsp_valid_ff    <= 1'b1;
            line_visible_ff <= line_visible_in;
            lines_done_ff   <= lines_done_in;
            pixel_x_ff      <= pixel_x_in;
            repeat_count_ff <= repeat_count_in;
            column_ff       <= column_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (settle_load) begin
         next_line_src_ff <= start_offset_ff;
      end else if (req_fire) begin
         next_line_src_ff <= next_line_src_in;
      end
      if (req_fire) begin
         line_base_ff <= line_base_in;
         show_ff      <= show_in;
         addr_ff      <= addr_in;
         lend_ff      <= lend_in;
         fdone_ff     <= fdone_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.show_source = show_ff;
   assign rsp_chan.src_addr    = addr_ff;
   assign rsp_chan.line_end    = lend_ff;
   assign rsp_chan.frame_done  = fdone_ff;

   a_no_accept_while_settling: assert property (
      @(posedge clock) disable iff (reset)
      (settle_cnt_ff != '0) |-> !req_chan.ready
   ) else $error("request accepted while derived values settle");

   a_response_follows_accept: assert property (
      @(posedge clock) disable iff (reset)
      req_fire |=> rsp_chan.valid
   ) else $error("accepted transaction produced no response");

   a_pixel_wraps_at_line_end: assert property (
      @(posedge clock) disable iff (reset)
      (req_fire && !req_chan.mode && pix_last) |=> (pixel_x_ff == '0)
   ) else $error("pixel counter did not wrap at panel line end");

   a_frame_done_is_black: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frame_done) |-> (!rsp_chan.show_source && !rsp_chan.line_end)
   ) else $error("frame end flagged on a pixel response");

endmodule

`default_nettype wire
